@@ hdl/bafr_pkg.sv @@
package bafr_pkg;

    localparam int MAX_KERNEL_DEF = 15;
    localparam int MAX_COLS_DEF   = 1024;
    localparam int MAX_ROWS_DEF   = 1024;

    localparam int KSIZE_W = 4;
    localparam int DIM_W   = 11;
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;

    localparam logic [KSIZE_W-1:0] KSIZE_RESET = 4'd11;
    localparam logic [DIM_W-1:0]   COLS_RESET  = 11'd640;
    localparam logic [DIM_W-1:0]   ROWS_RESET  = 11'd480;

    localparam logic [1:0] REG_KERNEL_SIZE = 2'd0;
    localparam logic [1:0] REG_FRAME_COLS  = 2'd1;
    localparam logic [1:0] REG_FRAME_ROWS  = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Window sum bound: 225 * 255 fits in 16 bits; divisor k*k below 256.
    localparam int SUM_W = 16;
    localparam int DIV_W = 8;

endpackage

@@ hdl/box_average_filter_replicate_unit.sv @@
// Streaming box-mean filter with replicate border. Pixels arrive in raster
// order; each output is the truncated mean of the odd k x k window around a
// frame position, lagging input by (k/2)*cols + k/2 pixels, with drain items
// bringing out the tail. Pixels are kept in one circular line store that is
// read one pixel per cycle. An item that releases an output is accepted, its
// window is swept and summed, the sum is divided and the result is presented
// until m_axis_tready takes it; no new item is accepted meanwhile. Items that
// release nothing leave the block idle. An even kernel size gives zero with
// kernel_error set, skipping the sweep and divider. A configuration write to
// one of the three registers restarts the frame.
module box_average_filter_replicate_unit
    import bafr_pkg::*;
#(
    parameter int MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // pixel_in
    input  logic             s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // pixel_out
    output logic             m_axis_tlast,   // frame_done
    output logic             m_axis_tuser,   // kernel_error
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_KERNEL * (MAX_COLS + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = 2 * DIM_W + 2;
    localparam int OFF_W  = ADDR_W + 2;
    localparam logic signed [OFF_W-1:0] DEPTH_S = OFF_W'(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SWEEP, S_DIV_START, S_DIV_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [KSIZE_W-1:0] ksize_reg;
    logic [DIM_W-1:0] cols_cfg_reg, rows_cfg_reg;
    logic [DIM_W-1:0] in_row_reg, in_col_reg, out_row_reg, out_col_reg;
    logic [ADDR_W-1:0] wr_addr_reg, out_addr_reg;
    logic [KSIZE_W:0] dr_reg, dc_reg;
    logic             rd_valid_reg, last_rd_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [7:0]       pix_reg;
    logic             done_reg, err_reg;

    // Effective dimensions.
    logic [DIM_W-1:0] cols, rows;
    always_comb
    begin
        cols = (cols_cfg_reg == '0) ? DIM_W'(1) :
               ((32'(cols_cfg_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_cfg_reg);
        rows = (rows_cfg_reg == '0) ? DIM_W'(1) :
               ((32'(rows_cfg_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_cfg_reg);
    end

    logic             ok;
    logic [KSIZE_W-1:0] h;
    assign ok = ksize_reg[0] && (32'(ksize_reg) <= MAX_KERNEL);
    assign h  = ok ? (ksize_reg >> 1) : '0;

    logic [IDX_W-1:0] total, lag, in_count, out_index;
    logic             pix_item, received, release_out;
    logic [DIM_W-1:0] in_row_n, in_col_n;

    assign total    = IDX_W'(cols) * IDX_W'(rows);
    assign lag      = IDX_W'(h) * IDX_W'(cols) + IDX_W'(h);
    assign pix_item = (in_row_reg < rows) && (s_axis_tuser == OP_PIXEL);

    always_comb
    begin
        in_row_n = in_row_reg;
        in_col_n = in_col_reg;
        if (pix_item)
        begin
            if (in_col_reg + 1'b1 >= cols)
            begin
                in_col_n = '0;
                in_row_n = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_n = in_col_reg + 1'b1;
            end
        end
    end

    assign received  = in_row_n >= rows;
    assign in_count  = received ? total : IDX_W'(in_row_n) * IDX_W'(cols) + IDX_W'(in_col_n);
    assign out_index = IDX_W'(out_row_reg) * IDX_W'(cols) + IDX_W'(out_col_reg);
    assign release_out = (out_index < total) && (received || in_count > out_index + lag);

    logic in_xfer;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Window read address with clamping.
    logic signed [DIM_W+1:0] rr, cc;
    logic [DIM_W-1:0] rr_c, cc_c;
    logic [ADDR_W-1:0] raddr;
    always_comb
    begin
        rr = $signed({2'b0, out_row_reg}) + $signed({{(DIM_W-3){1'b0}}, dr_reg})
             - $signed({{(DIM_W-2){1'b0}}, h});
        cc = $signed({2'b0, out_col_reg}) + $signed({{(DIM_W-3){1'b0}}, dc_reg})
             - $signed({{(DIM_W-2){1'b0}}, h});
        if (rr < 0)
            rr_c = '0;
        else if (rr > $signed({2'b0, rows}) - 1)
            rr_c = rows - 1'b1;
        else
            rr_c = rr[DIM_W-1:0];
        if (cc < 0)
            cc_c = '0;
        else if (cc > $signed({2'b0, cols}) - 1)
            cc_c = cols - 1'b1;
        else
            cc_c = cc[DIM_W-1:0];
    end

    // The window pixel sits at a small signed offset from the output position,
    // whose store address is tracked, so one wrap correction is enough.
    logic signed [OFF_W-1:0] row_off, col_off, rd_sum;
    assign row_off = $signed(OFF_W'(rr_c)) - $signed(OFF_W'(out_row_reg));
    assign col_off = $signed(OFF_W'(cc_c)) - $signed(OFF_W'(out_col_reg));
    assign rd_sum  = $signed(OFF_W'(out_addr_reg)) + row_off * $signed(OFF_W'(cols))
                     + col_off;
    assign raddr   = (rd_sum < 0) ? ADDR_W'(rd_sum + DEPTH_S) :
                     ((rd_sum >= DEPTH_S) ? ADDR_W'(rd_sum - DEPTH_S) : ADDR_W'(rd_sum));

    logic [7:0] rdata;
    bafr_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (in_xfer && pix_item),
        .waddr (wr_addr_reg),
        .wdata (s_axis_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic             div_start, div_busy;
    logic [SUM_W-1:0] quotient;
    logic [DIV_W-1:0] ksq;
    assign ksq = DIV_W'(ksize_reg) * DIV_W'(ksize_reg);
    assign div_start = (state_reg == S_DIV_START);
    bafr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (ksq),
        .busy     (div_busy),
        .quotient (quotient)
    );

    logic [KSIZE_W:0] kmax;
    assign kmax = {1'b0, ksize_reg} - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ksize_reg    <= KSIZE_RESET;
            cols_cfg_reg <= COLS_RESET;
            rows_cfg_reg <= ROWS_RESET;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            wr_addr_reg  <= '0;
            out_addr_reg <= '0;
            m_axis_tvalid <= 1'b0;
            rd_valid_reg <= 1'b0;
            last_rd_reg  <= 1'b0;
            dr_reg       <= '0;
            dc_reg       <= '0;
            sum_reg      <= '0;
            pix_reg      <= '0;
            done_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KERNEL_SIZE: ksize_reg    <= cfg_data[KSIZE_W-1:0];
                REG_FRAME_COLS:  cols_cfg_reg <= cfg_data[DIM_W-1:0];
                REG_FRAME_ROWS:  rows_cfg_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
            if (cfg_index == REG_KERNEL_SIZE || cfg_index == REG_FRAME_COLS ||
                cfg_index == REG_FRAME_ROWS)
            begin
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                wr_addr_reg  <= '0;
                out_addr_reg <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        in_row_reg <= in_row_n;
                        in_col_reg <= in_col_n;
                        if (pix_item)
                            wr_addr_reg <= (wr_addr_reg == ADDR_LAST) ? '0
                                                                      : wr_addr_reg + 1'b1;
                        if (release_out)
                        begin
                            done_reg <= (out_index == total - 1'b1);
                            err_reg  <= !ok;
                            dr_reg   <= '0;
                            dc_reg   <= '0;
                            sum_reg  <= '0;
                            rd_valid_reg <= 1'b0;
                            last_rd_reg  <= 1'b0;
                            state_reg <= ok ? S_SWEEP : S_OUT;
                            pix_reg  <= '0;
                        end
                    end
                end
                S_SWEEP:
                begin
                    // Issue one window read per cycle; accumulate the previous.
                    if (rd_valid_reg)
                        sum_reg <= sum_reg + SUM_W'(rdata);
                    if (last_rd_reg)
                    begin
                        rd_valid_reg <= 1'b0;
                        last_rd_reg  <= 1'b0;
                        state_reg    <= S_DIV_START;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b1;
                        if (dc_reg == kmax)
                        begin
                            dc_reg <= '0;
                            if (dr_reg == kmax)
                                last_rd_reg <= 1'b1;
                            else
                                dr_reg <= dr_reg + 1'b1;
                        end
                        else
                        begin
                            dc_reg <= dc_reg + 1'b1;
                        end
                    end
                end
                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (!div_busy)
                    begin
                        pix_reg   <= quotient[7:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_axis_tvalid)
                    begin
                        m_axis_tvalid <= 1'b1;
                        if (done_reg)
                        begin
                            in_row_reg   <= '0;
                            in_col_reg   <= '0;
                            out_row_reg  <= '0;
                            out_col_reg  <= '0;
                            wr_addr_reg  <= '0;
                            out_addr_reg <= '0;
                        end
                        else
                        begin
                            out_addr_reg <= (out_addr_reg == ADDR_LAST) ? '0
                                                                        : out_addr_reg + 1'b1;
                            if (out_col_reg + 1'b1 >= cols)
                            begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + 1'b1;
                            end
                            else
                            begin
                                out_col_reg <= out_col_reg + 1'b1;
                            end
                        end
                    end
                    else if (m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = pix_reg;
    assign m_axis_tlast = done_reg;
    assign m_axis_tuser = err_reg;

endmodule

@@ hdl/bafr_ram.sv @@
module bafr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/bafr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bafr_div
    import bafr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [SUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg;
    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W+1:0] shifted;

    assign shifted  = {rem_reg, quo_reg[SUM_W-1]};
    assign trial    = shifted[DIV_W:0] - {1'b0, dvs_reg};
    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(SUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            if (shifted >= {1'b0, 1'b0, dvs_reg})
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIV_W:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

endmodule

@@ hdl/bafr_checker.sv @@
module bafr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // The block holds one item at a time.
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while a result is pending");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
        else $error("kernel error result carries a nonzero pixel");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("not ready after result transfer");

endmodule

bind box_average_filter_replicate_unit bafr_checker u_bafr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ verif/tb_box_average_filter_replicate_unit.sv @@
module tb_box_average_filter_replicate_unit
    import bafr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = MAX_KERNEL_DEF * (MAX_COLS_DEF + 1);
    localparam int SETTLE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1700;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_done;
        logic             kernel_error;
    } mean_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

    typedef struct {
        row_kind_t    kind;
        logic [1:0]   sel;
        logic [10:0]  value;
        row_check_t   chk;
        mean_result_t res;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;
    logic             s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tlast;
    logic             m_axis_tuser;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    box_average_filter_replicate_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the filter state.
    logic [7:0]  pix_store [0:STORE_DEPTH-1];
    int          in_r, in_c, out_r, out_c;
    logic [3:0]  ksize;
    logic [10:0] ncols, nrows;
    bit          frame_closed;

    mean_result_t mean_q[$];
    int send_idle, recv_idle;
    int mismatches = 0;
    int results_seen = 0;
    int frames_closed = 0;
    int items_sent, phases;
    int quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit window_mean(input logic op, input logic [7:0] pix,
                                       output mean_result_t r);
        int cols, rows, total, h, lag, in_cnt, oidx, sum, rr, cc;
        bit ok, recv;
        cols = (ncols == 0) ? 1 : ((ncols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(ncols));
        rows = (nrows == 0) ? 1 : ((nrows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(nrows));
        total = cols * rows;
        ok = ksize[0] && (ksize <= MAX_KERNEL_DEF);
        h = ok ? ksize / 2 : 0;
        lag = h * cols + h;
        r = '0;
        if (in_r < rows && op == OP_PIXEL)
        begin
            pix_store[(in_r * cols + in_c) % STORE_DEPTH] = pix;
            in_c++;
            if (in_c >= cols)
            begin
                in_c = 0;
                in_r++;
            end
        end
        recv = in_r >= rows;
        in_cnt = recv ? total : in_r * cols + in_c;
        oidx = out_r * cols + out_c;
        if (oidx >= total)
            return 0;
        if (!recv && in_cnt <= oidx + lag)
            return 0;
        if (ok)
        begin
            sum = 0;
            for (int dr = -h; dr <= h; dr++)
            begin
                rr = out_r + dr;
                if (rr < 0) rr = 0;
                if (rr > rows - 1) rr = rows - 1;
                for (int dc = -h; dc <= h; dc++)
                begin
                    cc = out_c + dc;
                    if (cc < 0) cc = 0;
                    if (cc > cols - 1) cc = cols - 1;
                    sum += pix_store[(rr * cols + cc) % STORE_DEPTH];
                end
            end
            r.pixel = 8'(sum / (ksize * ksize));
        end
        r.kernel_error = !ok;
        if (oidx == total - 1)
        begin
            r.frame_done = 1'b1;
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        end
        else
        begin
            out_c++;
            if (out_c >= cols)
            begin
                out_c = 0;
                out_r++;
            end
        end
        return 1;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] pix, input row_check_t chk,
                             input mean_result_t typed);
        mean_result_t r;
        bit got;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = pix;
        s_axis_tuser = op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = window_mean(op, pix, r);
        if (got && r.frame_done)
            frame_closed = 1'b1;
        if (chk == CHK_MODEL && got)
            mean_q.push_back(r);
        else if (chk == CHK_ONE)
            mean_q.push_back(typed);
        items_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Registers change only once the filter has gone quiet.
    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        wait (mean_q.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_KERNEL_SIZE: ksize = value[3:0];
            REG_FRAME_COLS:  ncols = value;
            REG_FRAME_ROWS:  nrows = value;
            default: ;
        endcase
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (mean_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pixel=%0d done=%0b err=%0b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                mean_result_t e;
                e = mean_q.pop_front();
                if (e.frame_done)
                    frames_closed++;
                if (e.pixel !== m_axis_tdata || e.frame_done !== m_axis_tlast ||
                    e.kernel_error !== m_axis_tuser)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pixel=%0d done=%0b err=%0b, got %0d %0b %0b",
                                 e.pixel, e.frame_done, e.kernel_error,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    stim_row_t plan[$];

    function automatic void add_row(input row_kind_t kind, input logic [1:0] sel,
                                    input logic [10:0] value, input row_check_t chk,
                                    input logic [7:0] p, input logic d, input logic err);
        stim_row_t row;
        row.kind = kind;
        row.sel = sel;
        row.value = value;
        row.chk = chk;
        row.res.pixel = p;
        row.res.frame_done = d;
        row.res.kernel_error = err;
        plan.push_back(row);
    endfunction

    initial
    begin
        int cols, rows, npix, target;
        bit abort_frame, big_done;
        logic [3:0] k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_PIXEL;
        cfg_we = 1'b0;
        cfg_index = REG_KERNEL_SIZE;
        cfg_data = '0;
        send_idle = 34;
        recv_idle = 65;
        items_sent = 0;
        phases = 0; big_done = 0;
        ksize = KSIZE_RESET; ncols = COLS_RESET; nrows = ROWS_RESET;
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset the window lag is far beyond a handful of pixels.
        add_row(ROW_ITEM, 2'(OP_DRAIN), 0,   CHK_NONE, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 255, CHK_NONE, 0, 0, 0);
        // Even kernel: zero with the error flag, no lag.
        add_row(ROW_CFG,  REG_KERNEL_SIZE, 2, CHK_NONE, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 0,   CHK_ONE, 0, 0, 1);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 255, CHK_ONE, 0, 0, 1);
        add_row(ROW_ITEM, 2'(OP_DRAIN), 0,   CHK_NONE, 0, 0, 0);
        // One-pixel frame with unit kernel passes the pixel through.
        add_row(ROW_CFG,  REG_KERNEL_SIZE, 1, CHK_NONE, 0, 0, 0);
        add_row(ROW_CFG,  REG_FRAME_COLS,  1, CHK_NONE, 0, 0, 0);
        add_row(ROW_CFG,  REG_FRAME_ROWS,  1, CHK_NONE, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 255, CHK_ONE, 255, 1, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 0,   CHK_ONE, 0, 1, 0);
        add_row(ROW_CFG,  REG_KERNEL_SIZE, 0, CHK_NONE, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 7,   CHK_ONE, 0, 1, 1);
        // Zero dimensions act as one; the whole window replicates one pixel.
        add_row(ROW_CFG,  REG_KERNEL_SIZE, 15, CHK_NONE, 0, 0, 0);
        add_row(ROW_CFG,  REG_FRAME_COLS,  0, CHK_NONE, 0, 0, 0);
        add_row(ROW_CFG,  REG_FRAME_ROWS,  0, CHK_NONE, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 200, CHK_ONE, 200, 1, 0);
        add_row(ROW_CFG,  REG_FRAME_COLS,  3, CHK_NONE, 0, 0, 0);
        add_row(ROW_CFG,  REG_FRAME_ROWS,  2, CHK_NONE, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 10,  CHK_MODEL, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 250, CHK_MODEL, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 0,   CHK_MODEL, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 255, CHK_MODEL, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 128, CHK_MODEL, 0, 0, 0);
        add_row(ROW_ITEM, 2'(OP_PIXEL), 1,   CHK_MODEL, 0, 0, 0);
        // A pixel after the frame is complete behaves like a drain.
        add_row(ROW_ITEM, 2'(OP_PIXEL), 99,  CHK_MODEL, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            add_row(ROW_ITEM, 2'(OP_DRAIN), 0, CHK_MODEL, 0, 0, 0);

        @(negedge clk);
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].sel, plan[i].value);
            else
                send_item(plan[i].sel[0], plan[i].value[7:0], plan[i].chk, plan[i].res);
        end

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            int progress;
            progress = (RANDOM_ITEMS - (target - items_sent)) * 3 / RANDOM_ITEMS;
            send_idle = (progress == 0) ? 34 : ((progress == 1) ? 65 : 0);
            recv_idle = (progress == 0) ? 65 : ((progress == 1) ? 34 : 0);
            phases++;
            if (!big_done)
            begin
                // Widest frame: over-range column count clamps to the maximum.
                big_done = 1;
                k = 1;
                cols = MAX_COLS_DEF;
                rows = 1;
                write_reg(REG_KERNEL_SIZE, 11'(k));
                write_reg(REG_FRAME_COLS, 11'd2047);
                write_reg(REG_FRAME_ROWS, 11'd1);
            end
            else
            begin
                k = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 7) * 2 + 1)
                                              : 4'($urandom_range(0, 7) * 2);
                cols = $urandom_range(1, 8);
                rows = $urandom_range(1, 6);
                write_reg(REG_KERNEL_SIZE, 11'(k));
                write_reg(REG_FRAME_COLS, 11'(cols));
                write_reg(REG_FRAME_ROWS, 11'(rows));
            end
            frame_closed = 0;
            npix = cols * rows;
            abort_frame = ($urandom_range(0, 9) == 0);
            if (abort_frame)
                npix = $urandom_range(0, npix - 1);
            for (int i = 0; i < npix; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_DRAIN, 8'($urandom), CHK_MODEL, '0);
                else
                    send_item(OP_PIXEL, 8'($urandom), CHK_MODEL, '0);
            end
            if (!abort_frame)
            begin
                while (!frame_closed)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(OP_PIXEL, 8'($urandom), CHK_MODEL, '0);
                    else
                        send_item(OP_DRAIN, 8'($urandom), CHK_MODEL, '0);
                end
            end
        end

        wait (mean_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d items over %0d random frame setups; %0d results checked.",
                 items_sent, phases, results_seen);
        $display("Frames closed: %0d, mismatches: %0d.", frames_closed, mismatches);
        if (mismatches == 0 && mean_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bafr_pkg.sv
hdl/bafr_ram.sv
hdl/bafr_div.sv
hdl/box_average_filter_replicate_unit.sv
hdl/bafr_checker.sv
verif/tb_box_average_filter_replicate_unit.sv
